/* hdl/grd_pkg.sv */
package grd_pkg;

  // Field widths of the stream payloads
  localparam int ROW_W    = 16;
  localparam int WEIGHT_W = 8;
  localparam int GIDX_W   = 2;
  localparam int ISSUE_W  = 8;
  localparam int STALL_W  = 4;
  localparam int UNITS_W  = 11;
  localparam int FIN_W    = 32;
  localparam int OUT_DW   = 64;

  // Command codes carried in tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic REG_TOTAL_ROWS   = 1'b0;
  localparam logic REG_STALL_WEIGHT = 1'b1;

  // Per-group figures found by one lane
  typedef struct packed {
    logic [ISSUE_W-1:0] issued;
    logic [STALL_W-1:0] stalled;
    logic [UNITS_W-1:0] units;
    logic               sync;
  } lane_stat_t;

  // One result beat
  typedef struct packed {
    logic [GIDX_W-1:0]  group_index;
    logic [ROW_W-1:0]   work_row;
    logic [ISSUE_W-1:0] issued_mask;
    logic [STALL_W-1:0] stalled_count;
    logic [UNITS_W-1:0] stall_units;
    logic               row_advanced;
    logic [ROW_W-1:0]   next_work_row;
    logic               group_finished;
    logic               all_finished;
    logic               last;
  } result_t;

endpackage

/* hdl/grd_lane.sv */
module grd_lane #(
  parameter int BLOCKS_PER_GROUP = 8
) (
  input  logic [BLOCKS_PER_GROUP-1:0]     done_flags,
  input  logic [BLOCKS_PER_GROUP-1:0]     finish,
  input  logic [grd_pkg::WEIGHT_W-1:0]    stall_weight,
  output logic [BLOCKS_PER_GROUP-1:0]     done_after,
  output grd_pkg::lane_stat_t             stat
);
  import grd_pkg::*;

  localparam int CNT_W  = $clog2(BLOCKS_PER_GROUP + 1);
  localparam int PROD_W = CNT_W + WEIGHT_W + 1;

  logic [CNT_W-1:0]   stalled;
  logic [PROD_W-1:0]  prod;
  logic [ISSUE_W-1:0] issued;

  // Count idle blocks, mark busy ones that finish this tick
  always_comb begin
    stalled = '0;
    for (int k = 0; k < BLOCKS_PER_GROUP; k++) begin
      stalled = stalled + CNT_W'(done_flags[k]);
    end
    done_after = done_flags | finish;
  end

  // Show busy blocks on the first eight mask bits
  always_comb begin
    issued = '0;
    for (int k = 0; k < ISSUE_W; k++) begin
      if (k < BLOCKS_PER_GROUP) begin
        issued[k] = ~done_flags[k];
      end
    end
  end

  assign prod = PROD_W'(stalled) * PROD_W'(stall_weight);
  assign stat = {issued, STALL_W'(stalled), UNITS_W'(prod), &done_after};

endmodule

/* hdl/grd_merge.sv */
module grd_merge #(
  parameter int GROUPS = 4
) (
  input  logic [GROUPS-1:0]           sync,
  input  logic [grd_pkg::ROW_W-1:0]   row_ctr,
  input  logic [grd_pkg::ROW_W-1:0]   total_rows,
  output logic [GROUPS-1:0]           advance,
  output logic [grd_pkg::ROW_W-1:0]   new_row [GROUPS],
  output logic [grd_pkg::ROW_W-1:0]   row_ctr_nxt
);
  import grd_pkg::*;

  localparam int PW = $clog2(GROUPS + 1);

  // Hand out shared rows to syncing groups in ascending order
  always_comb begin
    logic [PW-1:0]  taken;
    logic [ROW_W:0] cand;
    taken = '0;
    cand  = '0;
    for (int d = 0; d < GROUPS; d++) begin
      cand       = {1'b0, row_ctr} + (ROW_W+1)'(taken);
      new_row[d] = cand[ROW_W-1:0];
      advance[d] = sync[d] && (cand < {1'b0, total_rows});
      taken      = taken + PW'(advance[d]);
    end
    row_ctr_nxt = row_ctr + ROW_W'(taken);
  end

endmodule

/* hdl/group_row_dispatch_sync_core.sv */
// Channel | Dir | Handshake                 | Payload
// in_     | in  | in_tvalid / in_tready     | tuser cmd, tdata block_finish
// out_    | out | out_tvalid / out_tready   | tdata result fields, tlast last
// cfg_    | in  | cfg_wen                   | cfg_index, cfg_wdata
//
// A tick beat updates the dispatch state in the cycle it is taken and yields
// GROUPS result beats, one per cycle while out_tready is high, from a shift
// buffer; a new beat is taken in the cycle the final result beat leaves.
// A start beat yields nothing and may be taken whenever in_tready is high.
// Synchronous active-low reset restores config, dispatch and count registers.
module group_row_dispatch_sync_core #(
  parameter int GROUPS           = 4,
  parameter int BLOCKS_PER_GROUP = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [grd_pkg::FIN_W-1:0]     in_tdata,  // [31:0] block_finish
  input  logic                          in_tuser,  // [0] cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] group_index, [17:2] work_row, [25:18] issued_mask,
  // [29:26] stalled_count, [40:30] stall_units, [41] row_advanced,
  // [57:42] next_work_row, [58] group_finished, [59] all_finished, [63:60] zero
  output logic [grd_pkg::OUT_DW-1:0]    out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_wen,
  input  logic                          cfg_index,
  input  logic [grd_pkg::ROW_W-1:0]     cfg_wdata
);
  import grd_pkg::*;

  localparam int NBLK  = GROUPS * BLOCKS_PER_GROUP;
  localparam int CNT_W = $clog2(GROUPS + 1);
  localparam int PAD_W = OUT_DW - $bits(result_t) + 1;

  logic [ROW_W-1:0]    total_rows_r;
  logic [WEIGHT_W-1:0] stall_weight_r;
  logic [ROW_W-1:0]    group_row_r [GROUPS];
  logic [NBLK-1:0]     done_r;
  logic [GROUPS-1:0]   gdone_r;
  logic [ROW_W-1:0]    ctr_r;

  logic [NBLK-1:0]     fin_all;
  logic [NBLK-1:0]     done_after;
  lane_stat_t          stat [GROUPS];
  logic [GROUPS-1:0]   sync;
  logic [GROUPS-1:0]   advance;
  logic [ROW_W-1:0]    new_row [GROUPS];
  logic [ROW_W-1:0]    ctr_nxt;

  logic [NBLK-1:0]     done_nxt;
  logic [GROUPS-1:0]   gdone_nxt;
  logic [ROW_W-1:0]    row_nxt [GROUPS];
  result_t             res [GROUPS];

  result_t             buf_r [GROUPS];
  logic [CNT_W-1:0]    cnt_r;

  logic in_beat, out_beat, tick_beat, start_beat;

  assign out_beat   = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == '0) || (out_beat && cnt_r == CNT_W'(1));
  assign in_beat    = in_tvalid && in_tready;
  assign tick_beat  = in_beat && (in_tuser == CMD_TICK);
  assign start_beat = in_beat && (in_tuser == CMD_START);

  // Spread finish bits over blocks; blocks past the bus never finish
  for (genvar b = 0; b < NBLK; b++) begin : g_fin
    if (b < FIN_W) begin : g_in
      assign fin_all[b] = in_tdata[b];
    end else begin : g_none
      assign fin_all[b] = 1'b0;
    end
  end

  // One lane per group
  for (genvar d = 0; d < GROUPS; d++) begin : g_lane
    grd_lane #(
      .BLOCKS_PER_GROUP (BLOCKS_PER_GROUP)
    ) u_lane (
      .done_flags   (done_r[d*BLOCKS_PER_GROUP +: BLOCKS_PER_GROUP]),
      .finish       (fin_all[d*BLOCKS_PER_GROUP +: BLOCKS_PER_GROUP]),
      .stall_weight (stall_weight_r),
      .done_after   (done_after[d*BLOCKS_PER_GROUP +: BLOCKS_PER_GROUP]),
      .stat         (stat[d])
    );
    assign sync[d] = stat[d].sync;
  end

  grd_merge #(
    .GROUPS (GROUPS)
  ) u_merge (
    .sync        (sync),
    .row_ctr     (ctr_r),
    .total_rows  (total_rows_r),
    .advance     (advance),
    .new_row     (new_row),
    .row_ctr_nxt (ctr_nxt)
  );

  // Form next state and the results of the tick
  always_comb begin
    for (int d = 0; d < GROUPS; d++) begin
      done_nxt[d*BLOCKS_PER_GROUP +: BLOCKS_PER_GROUP] =
        advance[d] ? '0 : done_after[d*BLOCKS_PER_GROUP +: BLOCKS_PER_GROUP];
      gdone_nxt[d] = gdone_r[d] || (sync[d] && !advance[d]);
      row_nxt[d]   = advance[d] ? new_row[d] : group_row_r[d];
    end
    for (int d = 0; d < GROUPS; d++) begin
      res[d].group_index    = GIDX_W'(d);
      res[d].work_row       = group_row_r[d];
      res[d].issued_mask    = stat[d].issued;
      res[d].stalled_count  = stat[d].stalled;
      res[d].stall_units    = stat[d].units;
      res[d].row_advanced   = advance[d];
      res[d].next_work_row  = row_nxt[d];
      res[d].group_finished = gdone_nxt[d];
      res[d].all_finished   = (d == GROUPS - 1) && (&gdone_nxt);
      res[d].last           = (d == GROUPS - 1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_rows_r   <= 16'd16;
      stall_weight_r <= 8'd8;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TOTAL_ROWS:   total_rows_r   <= cfg_wdata;
        REG_STALL_WEIGHT: stall_weight_r <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Dispatch state: restore on reset or start, advance on tick
  always_ff @(posedge clk) begin
    if (!rst_n || start_beat) begin
      for (int d = 0; d < GROUPS; d++) begin
        group_row_r[d] <= ROW_W'(d);
      end
      done_r  <= '0;
      gdone_r <= '0;
      ctr_r   <= ROW_W'(GROUPS);
    end else if (tick_beat) begin
      group_row_r <= row_nxt;
      done_r      <= done_nxt;
      gdone_r     <= gdone_nxt;
      ctr_r       <= ctr_nxt;
    end
  end

  // Result count: load on tick, drop one per output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (tick_beat) begin
      cnt_r <= CNT_W'(GROUPS);
    end else if (out_beat) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Result shift buffer: head entry drives the output
  always_ff @(posedge clk) begin
    if (tick_beat) begin
      buf_r <= res;
    end else if (out_beat) begin
      for (int d = 0; d < GROUPS - 1; d++) begin
        buf_r[d] <= buf_r[d+1];
      end
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = buf_r[0].last;
  assign out_tdata  = {PAD_W'(0),
                       buf_r[0].all_finished,
                       buf_r[0].group_finished,
                       buf_r[0].next_work_row,
                       buf_r[0].row_advanced,
                       buf_r[0].stall_units,
                       buf_r[0].stalled_count,
                       buf_r[0].issued_mask,
                       buf_r[0].work_row,
                       buf_r[0].group_index};

endmodule
